### rtl/tmas_pkg.sv
// shared constants, types and control structs for the trimmed mean supply scaler
package tmas_pkg;

  localparam int WINDOW   = 6;
  localparam int TRIM_DIV = WINDOW - 2;
  localparam int CODE_W   = 10;
  localparam int MV_W     = 15;
  localparam int IDX_W    = $clog2(WINDOW);
  localparam int SUM_W    = CODE_W + $clog2(WINDOW);

  localparam logic [63:0] SCALE_NUM = 64'd1158300;
  localparam logic [63:0] SCALE_DEN = 64'd52173;
  localparam int          MV_SHIFT  = 27;
  localparam int          MUL_W     = 32;
  localparam logic [63:0] SCALE_MUL_FULL =
    ((64'd1 << MV_SHIFT) * SCALE_NUM + SCALE_DEN - 64'd1) / SCALE_DEN;
  localparam logic [MUL_W-1:0] SCALE_MUL = SCALE_MUL_FULL[MUL_W-1:0];
  localparam int          PROD_W    = CODE_W + MUL_W;

  localparam logic OP_SAMPLE  = 1'b0;
  localparam logic OP_PROCESS = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_WALK,
    ST_TRIM,
    ST_MUL,
    ST_LOAD
  } state_t;

  typedef struct packed {
    logic             store;
    logic             walk;
    logic             walk_first;
    logic             trim;
    logic             mul;
    logic [IDX_W-1:0] wr_idx;
    logic [IDX_W-1:0] rd_idx;
  } lane_ctl_t;

endpackage

### rtl/trimmed_mean_adc_scaler.sv
// top level: control sequencer, three channel lanes and result register
// sample transaction: multiply and load steps, result valid after load, next accept once idle
// process transaction: same result and accept rules; the walk steps
// read the six ring entries, one per cycle in all three lanes at once,
// then trim, multiply, load
// one transaction in flight; a held result stalls the load step until taken
// reset clears the rings, write slot, seen flag and result valid
module trimmed_mean_adc_scaler (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic                        in_opcode,
  input  logic [tmas_pkg::CODE_W-1:0] in_raw_motor_supply,
  input  logic [tmas_pkg::CODE_W-1:0] in_raw_valve_supply,
  input  logic [tmas_pkg::CODE_W-1:0] in_raw_ignition,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [tmas_pkg::MV_W-1:0]   out_motor_supply_mv,
  output logic [tmas_pkg::MV_W-1:0]   out_valve_supply_mv,
  output logic [tmas_pkg::MV_W-1:0]   out_ignition_line_mv,
  output logic                        out_is_average,
  output logic                        out_data_valid
);
  import tmas_pkg::*;

  state_t           state_r, state_nxt;
  logic [IDX_W-1:0] cnt_r, cnt_nxt;
  logic [IDX_W-1:0] slot_r, slot_nxt;
  logic             seen_r, seen_nxt;
  logic             op_r;
  logic             in_fire;
  logic             load;
  lane_ctl_t        ctl;

  logic [MV_W-1:0]  motor_mv, valve_mv, ign_mv;
  logic             out_valid_r, out_valid_nxt;
  logic [MV_W-1:0]  motor_mv_r, valve_mv_r, ign_mv_r;
  logic             is_avg_r, data_valid_r;

  assign in_fire = in_valid && in_ready;
  assign load    = (state_r == ST_LOAD) && (!out_valid_r || out_ready);

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          state_nxt = (in_opcode == OP_PROCESS) ? ST_WALK : ST_MUL;
        end
      end
      ST_WALK: begin
        if (cnt_r == IDX_W'(WINDOW - 1)) begin
          state_nxt = ST_TRIM;
        end
      end
      ST_TRIM: state_nxt = ST_MUL;
      ST_MUL:  state_nxt = ST_LOAD;
      ST_LOAD: begin
        if (load) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready       = (state_r == ST_IDLE);
    ctl.store      = in_fire && (in_opcode == OP_SAMPLE);
    ctl.walk       = (state_r == ST_WALK);
    ctl.walk_first = (cnt_r == '0);
    ctl.trim       = (state_r == ST_TRIM);
    ctl.mul        = (state_r == ST_MUL);
    ctl.wr_idx     = slot_r;
    ctl.rd_idx     = cnt_r;
  end

  always_comb begin
    cnt_nxt  = cnt_r;
    slot_nxt = slot_r;
    seen_nxt = seen_r;
    if (in_fire) begin
      cnt_nxt = '0;
    end else if (state_r == ST_WALK) begin
      cnt_nxt = cnt_r + 1'b1;
    end
    if (ctl.store) begin
      slot_nxt = (slot_r == IDX_W'(WINDOW - 1)) ? '0 : slot_r + 1'b1;
      seen_nxt = 1'b1;
    end
    out_valid_nxt = out_valid_r;
    if (load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cnt_r       <= '0;
      slot_r      <= '0;
      seen_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      slot_r      <= slot_nxt;
      seen_r      <= seen_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      op_r <= in_opcode;
    end
    if (load) begin
      motor_mv_r   <= motor_mv;
      valve_mv_r   <= valve_mv;
      ign_mv_r     <= ign_mv;
      is_avg_r     <= op_r;
      data_valid_r <= seen_r;
    end
  end

  tmas_lane u_lane_motor (
    .clk   (clk),
    .rst_n (rst_n),
    .ctl   (ctl),
    .raw   (in_raw_motor_supply),
    .mv    (motor_mv)
  );

  tmas_lane u_lane_valve (
    .clk   (clk),
    .rst_n (rst_n),
    .ctl   (ctl),
    .raw   (in_raw_valve_supply),
    .mv    (valve_mv)
  );

  tmas_lane u_lane_ign (
    .clk   (clk),
    .rst_n (rst_n),
    .ctl   (ctl),
    .raw   (in_raw_ignition),
    .mv    (ign_mv)
  );

  assign out_valid            = out_valid_r;
  assign out_motor_supply_mv  = motor_mv_r;
  assign out_valve_supply_mv  = valve_mv_r;
  assign out_ignition_line_mv = ign_mv_r;
  assign out_is_average       = is_avg_r;
  assign out_data_valid       = data_valid_r;

endmodule

### rtl/tmas_lane.sv
// one channel lane: sample ring, min/max/sum walk, trim and millivolt scaling
module tmas_lane (
  input  logic                     clk,
  input  logic                     rst_n,
  input  tmas_pkg::lane_ctl_t      ctl,
  input  logic [tmas_pkg::CODE_W-1:0] raw,
  output logic [tmas_pkg::MV_W-1:0]   mv
);
  import tmas_pkg::*;

  logic [CODE_W-1:0] ring_r [WINDOW];
  logic [SUM_W-1:0]  sum_r;
  logic [CODE_W-1:0] min_r;
  logic [CODE_W-1:0] max_r;
  logic [CODE_W-1:0] operand_r;
  logic [PROD_W-1:0] prod_r;
  logic [CODE_W-1:0] rd_val;
  logic [SUM_W-1:0]  trim_sum;

  assign rd_val   = ring_r[ctl.rd_idx];
  assign trim_sum = sum_r - SUM_W'(min_r) - SUM_W'(max_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < WINDOW; i++) begin
        ring_r[i] <= '0;
      end
    end else if (ctl.store) begin
      ring_r[ctl.wr_idx] <= raw;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.walk) begin
      if (ctl.walk_first) begin
        sum_r <= SUM_W'(rd_val);
        min_r <= rd_val;
        max_r <= rd_val;
      end else begin
        sum_r <= sum_r + SUM_W'(rd_val);
        if (rd_val < min_r) begin
          min_r <= rd_val;
        end
        if (rd_val > max_r) begin
          max_r <= rd_val;
        end
      end
    end
    if (ctl.store) begin
      operand_r <= raw;
    end else if (ctl.trim) begin
      operand_r <= CODE_W'(trim_sum / TRIM_DIV);
    end
    if (ctl.mul) begin
      prod_r <= PROD_W'(operand_r) * PROD_W'(SCALE_MUL);
    end
  end

  assign mv = prod_r[MV_SHIFT +: MV_W];

endmodule

### test/tb_top.sv
// testbench for trimmed_mean_adc_scaler: drives samples and trimmed averages, scores each result
module tb_top;
  import tmas_pkg::*;

  typedef struct {
    bit [MV_W-1:0] motor_mv;
    bit [MV_W-1:0] valve_mv;
    bit [MV_W-1:0] ignition_line_mv;
    bit            is_average;
    bit            data_valid;
  } supply_reading_t;

  class supply_scoreboard;
    supply_reading_t pending_mv_q[$];
    bit [CODE_W-1:0] rings[3][WINDOW];
    int              write_slot;
    bit              seen_sample;
    int              errors;

    function new();
      foreach (rings[c, k]) rings[c][k] = '0;
      write_slot  = 0;
      seen_sample = 1'b0;
      errors      = 0;
    endfunction

    function bit [MV_W-1:0] code_to_mv(bit [CODE_W-1:0] code);
      bit [63:0] scaled;
      scaled = (64'(code) * 64'd1158300) / 64'd52173;
      return scaled[MV_W-1:0];
    endfunction

    function bit [CODE_W-1:0] olympic_mean(int ch);
      int unsigned total;
      int unsigned lo;
      int unsigned hi;
      total = 0;
      lo    = rings[ch][0];
      hi    = rings[ch][0];
      for (int k = 0; k < WINDOW; k++) begin
        if (rings[ch][k] < lo) lo = rings[ch][k];
        if (rings[ch][k] > hi) hi = rings[ch][k];
        total += rings[ch][k];
      end
      return CODE_W'((total - lo - hi) / (WINDOW - 2));
    endfunction

    function void accept_reading(logic op, logic [CODE_W-1:0] motor, logic [CODE_W-1:0] valve,
                                 logic [CODE_W-1:0] ignition);
      supply_reading_t r;
      if (op == OP_SAMPLE) begin
        rings[0][write_slot] = motor;
        rings[1][write_slot] = valve;
        rings[2][write_slot] = ignition;
        write_slot  = (write_slot + 1 >= WINDOW) ? 0 : write_slot + 1;
        seen_sample = 1'b1;
        r.motor_mv         = code_to_mv(motor);
        r.valve_mv         = code_to_mv(valve);
        r.ignition_line_mv = code_to_mv(ignition);
        r.is_average       = 1'b0;
        r.data_valid       = 1'b1;
      end else begin
        r.motor_mv         = code_to_mv(olympic_mean(0));
        r.valve_mv         = code_to_mv(olympic_mean(1));
        r.ignition_line_mv = code_to_mv(olympic_mean(2));
        r.is_average       = 1'b1;
        r.data_valid       = seen_sample;
      end
      pending_mv_q.push_back(r);
    endfunction

    function void match_field(string field, int unsigned want, int unsigned got);
      if (want != got) begin
        $error("%s expected %0d got %0d", field, want, got);
        errors++;
      end
    endfunction

    function void check_millivolts(logic [MV_W-1:0] motor, logic [MV_W-1:0] valve,
                                   logic [MV_W-1:0] ignition, logic avg, logic dv);
      supply_reading_t w;
      if (pending_mv_q.size() == 0) begin
        $error("result transaction with no expected reading");
        errors++;
      end else begin
        w = pending_mv_q.pop_front();
        match_field("motor_supply_mv", w.motor_mv, motor);
        match_field("valve_supply_mv", w.valve_mv, valve);
        match_field("ignition_line_mv", w.ignition_line_mv, ignition);
        match_field("is_average", w.is_average, avg);
        match_field("data_valid", w.data_valid, dv);
      end
    endfunction
  endclass

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              in_valid = 1'b0;
  logic              in_ready;
  logic              in_opcode = OP_SAMPLE;
  logic [CODE_W-1:0] in_raw_motor_supply = '0;
  logic [CODE_W-1:0] in_raw_valve_supply = '0;
  logic [CODE_W-1:0] in_raw_ignition = '0;
  logic              out_valid;
  logic              out_ready = 1'b0;
  logic [MV_W-1:0]   out_motor_supply_mv;
  logic [MV_W-1:0]   out_valve_supply_mv;
  logic [MV_W-1:0]   out_ignition_line_mv;
  logic              out_is_average;
  logic              out_data_valid;

  bit               calm = 1'b0;
  int               sent_count = 0;
  supply_scoreboard sb;

  trimmed_mean_adc_scaler dut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_valid),
    .in_ready            (in_ready),
    .in_opcode           (in_opcode),
    .in_raw_motor_supply (in_raw_motor_supply),
    .in_raw_valve_supply (in_raw_valve_supply),
    .in_raw_ignition     (in_raw_ignition),
    .out_valid           (out_valid),
    .out_ready           (out_ready),
    .out_motor_supply_mv (out_motor_supply_mv),
    .out_valve_supply_mv (out_valve_supply_mv),
    .out_ignition_line_mv(out_ignition_line_mv),
    .out_is_average      (out_is_average),
    .out_data_valid      (out_data_valid)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  initial begin
    #2000000;
    $display("tb_top failed");
    $finish;
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      sb.check_millivolts(out_motor_supply_mv, out_valve_supply_mv, out_ignition_line_mv,
                          out_is_average, out_data_valid);
    end
    out_ready <= calm || ($urandom_range(0, 99) >= 33);
  end

  function automatic logic [CODE_W-1:0] pick_code();
    int r;
    r = $urandom_range(0, 9);
    if (r < 2) return $urandom_range(0, 1) ? '1 : '0;
    if (r < 4) return CODE_W'($urandom_range(508, 512));
    return CODE_W'($urandom);
  endfunction

  task automatic send_item(input logic op, input logic [CODE_W-1:0] motor,
                           input logic [CODE_W-1:0] valve, input logic [CODE_W-1:0] ignition);
    calm = (sent_count >= 150) && (sent_count < 240);
    while (!calm && $urandom_range(0, 99) < 33) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid            <= 1'b1;
    in_opcode           <= op;
    in_raw_motor_supply <= motor;
    in_raw_valve_supply <= valve;
    in_raw_ignition     <= ignition;
    do @(posedge clk); while (!in_ready);
    sb.accept_reading(op, motor, valve, ignition);
    sent_count++;
  endtask

  task automatic send_random_process();
    send_item(OP_PROCESS, CODE_W'($urandom), CODE_W'($urandom), CODE_W'($urandom));
  endtask

  // ties on both the minimum and the maximum
  task automatic send_process_and_ties();
    send_item(OP_SAMPLE, '1, '0, 10'd7);
    send_item(OP_SAMPLE, '1, '0, 10'd7);
    send_item(OP_SAMPLE, '0, '1, 10'd7);
    send_item(OP_SAMPLE, '0, '1, 10'd7);
    send_item(OP_PROCESS, '0, '1, '0);
  endtask

  initial begin
    int burst;
    sb = new();
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // average before any sample, raw fields ignored
    send_item(OP_PROCESS, '1, '1, '1);
    send_item(OP_SAMPLE, '0, '0, '0);
    send_item(OP_SAMPLE, '1, '1, '1);
    // partly filled rings count unwritten entries as zero
    send_item(OP_PROCESS, '0, '0, '0);
    send_item(OP_SAMPLE, 10'd1, 10'd512, 10'd1022);
    send_item(OP_SAMPLE, 10'h2AA, 10'h155, '1);
    send_process_and_ties();
    // wrap of the write slot
    for (int k = 0; k < 7; k++)
      send_item(OP_SAMPLE, CODE_W'(k * 146), CODE_W'(1023 - k * 100), CODE_W'(k * 3 + 1));
    send_item(OP_PROCESS, '1, '0, 10'h155);

    while (sent_count < 422) begin
      if ($urandom_range(0, 9) < 8) begin
        burst = $urandom_range(1, 8);
        repeat (burst) send_item(OP_SAMPLE, pick_code(), pick_code(), pick_code());
        send_random_process();
      end else begin
        send_item(1'($urandom), CODE_W'($urandom), CODE_W'($urandom), CODE_W'($urandom));
      end
    end
    calm = 1'b0;
    in_valid <= 1'b0;

    while (sb.pending_mv_q.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (sb.errors == 0)
      $display("tb_top passed");
    else
      $display("tb_top failed");
    $finish;
  end

endmodule
